// File: src/countdown_timer_with_actions_top_assert.svh
// ----------------------------------------------------------------------------
// Countdown timer assertion macros
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef COUNTDOWN_TIMER_WITH_ACTIONS_TOP_ASSERT_SVH
`define COUNTDOWN_TIMER_WITH_ACTIONS_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define CTWA_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("countdown timer assertion failed");

// Next-cycle implication, disabled during reset.
`define CTWA_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("countdown timer assertion failed");

`else

`define CTWA_ASSERT_IMP(label, clk, rst, ante, cons)
`define CTWA_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/ctwa_pkg.sv
// ----------------------------------------------------------------------------
// Countdown timer package
// Codes, constants and structures shared by the countdown timer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ctwa_pkg;

  localparam int unsigned SecW    = 31;
  localparam int unsigned StampW  = 32;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned EnableW = 5;
  localparam int unsigned AmountW = 28;
  localparam int unsigned CodeW   = 3;

  localparam logic [SecW-1:0]    MaxSec        = {SecW{1'b1}};
  localparam logic [PeriodW-1:0] PeriodReset   = 16'd1000;
  localparam logic [EnableW-1:0] EnableReset   = 5'd0;
  localparam int unsigned        DebugBit      = 4;

  // Command codes.
  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_SET      = 3'd1;
  localparam logic [2:0] FUNC_SET_KEEP = 3'd2;
  localparam logic [2:0] FUNC_ADD      = 3'd3;
  localparam logic [2:0] FUNC_SUB      = 3'd4;
  localparam logic [2:0] FUNC_RESET    = 3'd5;
  localparam logic [2:0] FUNC_ACTION   = 3'd6;

  // Time units.
  localparam logic [1:0] UNIT_SEC  = 2'd0;
  localparam logic [1:0] UNIT_MIN  = 2'd1;
  localparam logic [1:0] UNIT_HOUR = 2'd2;

  // Timer actions; event codes use the same encoding.
  localparam logic [CodeW-1:0] ACT_NONE  = 3'd0;
  localparam logic [CodeW-1:0] ACT_START = 3'd1;
  localparam logic [CodeW-1:0] ACT_STOP  = 3'd2;
  localparam logic [CodeW-1:0] ACT_PAUSE = 3'd3;
  localparam logic [CodeW-1:0] ACT_END   = 3'd4;

  // Register indexes.
  localparam logic REG_TICK_PERIOD  = 1'b0;
  localparam logic REG_EVENT_ENABLE = 1'b1;

  typedef struct packed {
    logic [PeriodW-1:0] tick_period_ms;
    logic [EnableW-1:0] event_enable;
  } ctwa_cfg_t;

  typedef struct packed {
    logic [SecW-1:0]   remaining;
    logic [SecW-1:0]   elapsed;
    logic [CodeW-1:0]  action;
    logic [StampW-1:0] last_stamp;
  } ctwa_state_t;

  typedef struct packed {
    logic [2:0]        func;
    logic [StampW-1:0] now_ms;
    logic [15:0]       time_value;
    logic [1:0]        time_unit;
    logic [1:0]        action_code;
  } ctwa_item_t;

  typedef struct packed {
    logic [SecW-1:0]  remaining_seconds;
    logic [CodeW-1:0] current_action;
    logic [CodeW-1:0] event_code;
    logic             debug_valid;
  } ctwa_result_t;

endpackage

// File: src/ctwa_if.sv
// ----------------------------------------------------------------------------
// Countdown timer channels
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ctwa_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [31:0] now_ms;
  logic [15:0] time_value;
  logic [1:0]  time_unit;
  logic [1:0]  action_code;

  modport source (output valid, output func, output now_ms, output time_value,
                  output time_unit, output action_code, input ready);
  modport sink   (input valid, input func, input now_ms, input time_value,
                  input time_unit, input action_code, output ready);
endinterface

interface ctwa_res_if;
  logic        valid;
  logic        ready;
  logic [30:0] remaining_seconds;
  logic [2:0]  current_action;
  logic [2:0]  event_code;
  logic        debug_valid;

  modport source (output valid, output remaining_seconds, output current_action,
                  output event_code, output debug_valid, input ready);
  modport sink   (input valid, input remaining_seconds, input current_action,
                  input event_code, input debug_valid, output ready);
endinterface

// File: src/ctwa_regs.sv
// ----------------------------------------------------------------------------
// Countdown timer registers
// APB-style configuration registers: tick period and event enable mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctwa_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output ctwa_pkg::ctwa_cfg_t cfg
);

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_period_ms <= ctwa_pkg::PeriodReset;
      cfg.event_enable   <= ctwa_pkg::EnableReset;
    end else if (wr_en) begin
      case (reg_idx)
        ctwa_pkg::REG_TICK_PERIOD:  cfg.tick_period_ms <= pwdata[ctwa_pkg::PeriodW-1:0];
        ctwa_pkg::REG_EVENT_ENABLE: cfg.event_enable   <= pwdata[ctwa_pkg::EnableW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ctwa_pkg::REG_TICK_PERIOD:
        prdata = {{(32 - ctwa_pkg::PeriodW){1'b0}}, cfg.tick_period_ms};
      ctwa_pkg::REG_EVENT_ENABLE:
        prdata = {{(32 - ctwa_pkg::EnableW){1'b0}}, cfg.event_enable};
      default:
        prdata = 32'd0;
    endcase
  end

endmodule

// File: src/ctwa_step.sv
// ----------------------------------------------------------------------------
// Countdown timer step logic
// Next state and result for one command item, given the current state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ctwa_step (
  input  ctwa_pkg::ctwa_cfg_t    cfg,
  input  ctwa_pkg::ctwa_state_t  st,
  input  ctwa_pkg::ctwa_item_t   item,
  output ctwa_pkg::ctwa_state_t  st_next,
  output ctwa_pkg::ctwa_result_t res
);

  logic [ctwa_pkg::AmountW-1:0] amount;
  logic [ctwa_pkg::StampW-1:0]  stamp_diff;
  logic                         period_passed;
  logic                         running;
  logic [ctwa_pkg::SecW:0]      add_sum;
  logic                         act_req;
  logic [ctwa_pkg::CodeW-1:0]   act_code;
  logic [2:0]                   en_idx;
  logic                         dbg;
  logic [ctwa_pkg::CodeW-1:0]   ev;
  logic [ctwa_pkg::SecW-1:0]    amount_ext;

  always_comb begin
    case (item.time_unit)
      ctwa_pkg::UNIT_SEC:  amount = {12'd0, item.time_value};
      ctwa_pkg::UNIT_MIN:  amount = {12'd0, item.time_value} * 28'd60;
      ctwa_pkg::UNIT_HOUR: amount = {12'd0, item.time_value} * 28'd3600;
      default:             amount = '0;
    endcase
  end

  assign amount_ext    = {3'd0, amount};
  assign stamp_diff    = item.now_ms - st.last_stamp;
  assign period_passed = stamp_diff >= {16'd0, cfg.tick_period_ms};
  assign running       = (st.action == ctwa_pkg::ACT_START) ||
                         (st.action == ctwa_pkg::ACT_PAUSE);
  assign add_sum       = {1'b0, st.remaining} + {4'd0, amount};
  assign en_idx        = act_code - 3'd1;

  always_comb begin
    st_next  = st;
    act_req  = 1'b0;
    act_code = ctwa_pkg::ACT_END;
    dbg      = 1'b0;
    ev       = ctwa_pkg::ACT_NONE;

    case (item.func)
      ctwa_pkg::FUNC_TICK: begin
        if (period_passed) begin
          if (st.action == ctwa_pkg::ACT_START) begin
            if (st.remaining != '0) begin
              st_next.remaining = st.remaining - 31'd1;
            end
            if (st.elapsed != ctwa_pkg::MaxSec) begin
              st_next.elapsed = st.elapsed + 31'd1;
            end
          end else if (st.action == ctwa_pkg::ACT_STOP) begin
            st_next.remaining = '0;
            st_next.elapsed   = '0;
          end
          dbg                = running && cfg.event_enable[ctwa_pkg::DebugBit];
          st_next.last_stamp = item.now_ms;
        end
        // The end check uses the running test taken before the tick.
        act_req = running && (st_next.remaining == '0);
      end
      ctwa_pkg::FUNC_SET: begin
        st_next.elapsed   = '0;
        st_next.remaining = amount_ext;
      end
      ctwa_pkg::FUNC_SET_KEEP: begin
        st_next.remaining = (amount_ext > st.elapsed) ? amount_ext - st.elapsed : '0;
        st_next.elapsed   = '0;
      end
      ctwa_pkg::FUNC_ADD: begin
        st_next.remaining = add_sum[ctwa_pkg::SecW] ? ctwa_pkg::MaxSec
                                                    : add_sum[ctwa_pkg::SecW-1:0];
      end
      ctwa_pkg::FUNC_SUB: begin
        st_next.remaining = (amount_ext >= st.remaining) ? '0 : st.remaining - amount_ext;
      end
      ctwa_pkg::FUNC_RESET: begin
        st_next.remaining = '0;
        st_next.elapsed   = '0;
      end
      ctwa_pkg::FUNC_ACTION: begin
        act_req  = 1'b1;
        act_code = {1'b0, item.action_code} + 3'd1;
      end
      default: ;
    endcase

    // The last action taken is always the active one, so a request equal
    // to it is a repeat and is dropped.
    if (act_req && (act_code != st.action)) begin
      st_next.action = act_code;
      ev = cfg.event_enable[en_idx] ? act_code : ctwa_pkg::ACT_NONE;
    end
  end

  assign res.remaining_seconds = st_next.remaining;
  assign res.current_action    = st_next.action;
  assign res.event_code        = ev;
  assign res.debug_valid       = dbg;

endmodule

// File: src/countdown_timer_with_actions_top.sv
// Result: registered into the output entry, or the skid entry while that is held.
// Throughput: one command per cycle while the skid entry is empty; the state
// update is a single pass of add, compare and constant-multiply logic, and a
// two-entry output buffer keeps commands flowing while a result waits for the sink.
// Reset: synchronous; clears the timer state and the output buffer and
// loads the register defaults (tick period 1000 ms, events disabled).
// ----------------------------------------------------------------------------
// Countdown timer with actions
// Top level: command channel, timer state, output buffer and APB registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "countdown_timer_with_actions_top_assert.svh"

module countdown_timer_with_actions_top (
  input  logic        clk,
  input  logic        rst,
  ctwa_cmd_if.sink    cmd,
  ctwa_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctwa_pkg::ctwa_cfg_t    cfg;
  ctwa_pkg::ctwa_state_t  state;
  ctwa_pkg::ctwa_state_t  state_next;
  ctwa_pkg::ctwa_item_t   item;
  ctwa_pkg::ctwa_result_t step_res;
  ctwa_pkg::ctwa_result_t out_data;
  ctwa_pkg::ctwa_result_t skid_data;
  logic                   out_valid;
  logic                   skid_valid;
  logic                   cmd_fire;
  logic                   out_pop;

  ctwa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item.func        = cmd.func;
  assign item.now_ms      = cmd.now_ms;
  assign item.time_value  = cmd.time_value;
  assign item.time_unit   = cmd.time_unit;
  assign item.action_code = cmd.action_code;

  ctwa_step u_step (
    .cfg     (cfg),
    .st      (state),
    .item    (item),
    .st_next (state_next),
    .res     (step_res)
  );

  assign cmd.ready = !skid_valid;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign out_pop   = out_valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.remaining  <= '0;
      state.elapsed    <= '0;
      state.action     <= ctwa_pkg::ACT_NONE;
      state.last_stamp <= '0;
    end else if (cmd_fire) begin
      state <= state_next;
    end
  end

  // Two-entry output buffer: the skid entry catches a transfer that
  // arrives while the output entry is still held by the sink.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (cmd_fire) begin
      if (!out_valid || out_pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        out_data <= skid_data;
      end
    end else if (cmd_fire) begin
      if (!out_valid || out_pop) begin
        out_data <= step_res;
      end else begin
        skid_data <= step_res;
      end
    end
  end

  assign res.valid             = out_valid;
  assign res.remaining_seconds = out_data.remaining_seconds;
  assign res.current_action    = out_data.current_action;
  assign res.event_code        = out_data.event_code;
  assign res.debug_valid       = out_data.debug_valid;

  `CTWA_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `CTWA_ASSERT_NXT(a_stall_fills_skid, clk, rst,
                   cmd_fire && out_valid && !res.ready, skid_valid)
  `CTWA_ASSERT_IMP(a_event_matches_action, clk, rst,
                   cmd_fire && (step_res.event_code != ctwa_pkg::ACT_NONE),
                   step_res.event_code == step_res.current_action)
  `CTWA_ASSERT_NXT(a_state_holds_idle, clk, rst, !cmd_fire, state == $past(state))

endmodule

// File: tb/countdown_timer_checker.sv
// ----------------------------------------------------------------------------
// Countdown timer checker
// Watches the command, result and register ports, keeps its own copy of the
// timer state and compares every result transfer with the predicted value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module countdown_timer_checker
  import ctwa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ctwa_cmd_if         cmd,
  ctwa_res_if         res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int unsigned mismatches,
  output int unsigned outstanding
);

  logic [PeriodW-1:0] period_ms;
  logic [EnableW-1:0] enable_mask;
  logic [SecW-1:0]    remaining;
  logic [SecW-1:0]    elapsed;
  logic [CodeW-1:0]   action_now;
  logic [CodeW-1:0]   action_prev;
  logic [StampW-1:0]  last_stamp;
  ctwa_result_t       readouts[$];
  int unsigned        fail_count;

  function automatic logic [31:0] seconds_of(logic [15:0] value, logic [1:0] unit);
    case (unit)
      UNIT_SEC:  return {16'd0, value};
      UNIT_MIN:  return {16'd0, value} * 32'd60;
      UNIT_HOUR: return {16'd0, value} * 32'd3600;
      default:   return '0;
    endcase
  endfunction

  // A request equal to the last action taken is dropped without an event.
  function automatic logic [CodeW-1:0] take_action(logic [CodeW-1:0] code);
    if (code == action_prev) return ACT_NONE;
    action_now  = code;
    action_prev = code;
    return enable_mask[code - 3'd1] ? code : ACT_NONE;
  endfunction

  function automatic ctwa_result_t advance_timer(ctwa_item_t it);
    logic [31:0]  amount;
    logic [31:0]  delta;
    logic [31:0]  wide;
    logic         running;
    ctwa_result_t r;
    amount = seconds_of(it.time_value, it.time_unit);
    r = '0;
    case (it.func)
      FUNC_TICK: begin
        // The end check uses the action as it stood before this tick.
        running = (action_now == ACT_START) || (action_now == ACT_PAUSE);
        delta = it.now_ms - last_stamp;
        if (delta >= {16'd0, period_ms}) begin
          if (action_now == ACT_START) begin
            if (remaining != '0) remaining = remaining - 31'd1;
            if (elapsed != MaxSec) elapsed = elapsed + 31'd1;
          end else if (action_now == ACT_STOP) begin
            remaining = '0;
            elapsed   = '0;
          end
          r.debug_valid = running & enable_mask[DebugBit];
          last_stamp = it.now_ms;
        end
        if (remaining == '0 && running) r.event_code = take_action(ACT_END);
      end
      FUNC_SET: begin
        elapsed   = '0;
        remaining = amount[SecW-1:0];
      end
      FUNC_SET_KEEP: begin
        wide = amount - {1'b0, elapsed};
        remaining = (amount > {1'b0, elapsed}) ? wide[SecW-1:0] : '0;
        elapsed = '0;
      end
      FUNC_ADD: begin
        wide = {1'b0, remaining} + amount;
        remaining = (wide > {1'b0, MaxSec}) ? MaxSec : wide[SecW-1:0];
      end
      FUNC_SUB: begin
        remaining = (amount >= {1'b0, remaining}) ? '0 : remaining - amount[SecW-1:0];
      end
      FUNC_RESET: begin
        remaining = '0;
        elapsed   = '0;
      end
      FUNC_ACTION: r.event_code = take_action({1'b0, it.action_code} + 3'd1);
      default: ;
    endcase
    r.remaining_seconds = remaining;
    r.current_action    = action_now;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    ctwa_result_t want;
    ctwa_item_t   it;
    if (rst) begin
      period_ms   = PeriodReset;
      enable_mask = EnableReset;
      remaining   = '0;
      elapsed     = '0;
      action_now  = ACT_NONE;
      action_prev = ACT_NONE;
      last_stamp  = '0;
      readouts.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_TICK_PERIOD, 2'b00}) period_ms = pwdata[PeriodW-1:0];
        else if (paddr == {REG_EVENT_ENABLE, 2'b00}) enable_mask = pwdata[EnableW-1:0];
      end
      // Results leave before the command of the same edge is predicted,
      // since a result never appears in the cycle of its own command.
      if (res.valid && res.ready) begin
        if (readouts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: remaining %0d action %0d event %0d debug %0b",
                     res.remaining_seconds, res.current_action, res.event_code,
                     res.debug_valid);
        end else begin
          want = readouts.pop_front();
          if (res.remaining_seconds !== want.remaining_seconds ||
              res.current_action !== want.current_action ||
              res.event_code !== want.event_code ||
              res.debug_valid !== want.debug_valid) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected remaining %0d action %0d event %0d debug %0b, %s",
                       want.remaining_seconds, want.current_action, want.event_code,
                       want.debug_valid,
                       $sformatf("got remaining %0d action %0d event %0d debug %0b",
                                 res.remaining_seconds, res.current_action,
                                 res.event_code, res.debug_valid));
          end
        end
      end
      if (cmd.valid && cmd.ready) begin
        it.func        = cmd.func;
        it.now_ms      = cmd.now_ms;
        it.time_value  = cmd.time_value;
        it.time_unit   = cmd.time_unit;
        it.action_code = cmd.action_code;
        readouts.push_back(advance_timer(it));
      end
    end
    mismatches  <= fail_count;
    outstanding <= readouts.size();
  end

endmodule

// File: tb/countdown_timer_with_actions_top_tb.sv
// ----------------------------------------------------------------------------
// Countdown timer testbench
// Drives directed and random command sequences with random idling on both
// channels across several register settings; the checker does the scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module countdown_timer_with_actions_top_tb;
  import ctwa_pkg::*;

  localparam logic [2:0] FUNC_UNUSED   = 3'd7;
  localparam logic [1:0] UNIT_NONE     = 2'd3;
  localparam logic [1:0] REQ_START     = 2'd0;
  localparam logic [1:0] REQ_STOP      = 2'd1;
  localparam logic [1:0] REQ_PAUSE     = 2'd2;
  localparam logic [1:0] REQ_END       = 2'd3;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned PHASE_ITEMS   = 245;
  localparam int unsigned SETTLE_CYCLES = 10;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned stall_cycles;
  int unsigned items_sent;
  logic [31:0] clock_ms;
  logic [15:0] period_now;
  bit          src_idle_en;
  bit          snk_idle_en;

  ctwa_cmd_if cmd_ch ();
  ctwa_res_if res_ch ();

  countdown_timer_with_actions_top dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  countdown_timer_checker timer_check (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_ch),
    .res         (res_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result sink: ready drops in short random bursts while idling is enabled.
  initial begin
    forever begin
      if (snk_idle_en && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic ctwa_item_t make_cmd(logic [2:0] func, logic [15:0] value,
                                          logic [1:0] unit, logic [1:0] code,
                                          logic [31:0] now);
    ctwa_item_t it;
    it.func        = func;
    it.now_ms      = now;
    it.time_value  = value;
    it.time_unit   = unit;
    it.action_code = code;
    return it;
  endfunction

  // Ticks move the local clock forward by up to two periods plus three ms, so
  // roughly half of them complete a period; now and then a stamp jumps anywhere.
  function automatic ctwa_item_t rand_cmd();
    int unsigned pick;
    logic [15:0] value;
    logic [1:0]  unit;
    logic [2:0]  func;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) begin
      value = 16'($urandom);
      unit  = 2'($urandom_range(0, 3));
    end else begin
      value = 16'($urandom_range(0, 12));
      unit  = UNIT_SEC;
    end
    if (pick < 45)      func = FUNC_TICK;
    else if (pick < 65) func = FUNC_ACTION;
    else if (pick < 73) func = FUNC_SET;
    else if (pick < 78) func = FUNC_SET_KEEP;
    else if (pick < 85) func = FUNC_ADD;
    else if (pick < 92) func = FUNC_SUB;
    else if (pick < 96) func = FUNC_RESET;
    else                func = FUNC_UNUSED;
    if (func == FUNC_TICK) begin
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, 2 * period_now + 3);
    end
    return make_cmd(func, value, unit, 2'($urandom_range(0, 3)), clock_ms);
  endfunction

  task automatic send(input ctwa_item_t it);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.func        <= it.func;
    cmd_ch.now_ms      <= it.now_ms;
    cmd_ch.time_value  <= it.time_value;
    cmd_ch.time_unit   <= it.time_unit;
    cmd_ch.action_code <= it.action_code;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (it.func != FUNC_UNUSED) items_sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] period, input logic [4:0] enable);
    write_reg(REG_TICK_PERIOD, {16'd0, period});
    write_reg(REG_EVENT_ENABLE, {27'd0, enable});
    period_now = period;
  endtask

  // Let every outstanding result come back with no command offered.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Mostly a load and a start followed by random traffic; some episodes skip
  // the preamble so that commands also hit an idle or ended timer.
  task automatic run_episode();
    int unsigned n;
    if ($urandom_range(0, 4) != 0) begin
      send(make_cmd(FUNC_SET, 16'($urandom_range(1, 6)), UNIT_SEC, REQ_START, clock_ms));
      send(make_cmd(FUNC_ACTION, 16'($urandom), 2'($urandom_range(0, 3)), REQ_START,
                    clock_ms));
    end
    n = $urandom_range(4, 20);
    repeat (n) send(rand_cmd());
  endtask

  initial begin
    int unsigned target;
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.func        <= FUNC_TICK;
    cmd_ch.now_ms      <= '0;
    cmd_ch.time_value  <= '0;
    cmd_ch.time_unit   <= UNIT_SEC;
    cmd_ch.action_code <= REQ_START;
    clock_ms   = '0;
    period_now = PeriodReset;
    items_sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;

    // Zero period, every event reported: each tick completes a period.
    configure(16'd0, 5'h1F);
    send(make_cmd(FUNC_UNUSED, 16'hFFFF, UNIT_NONE, REQ_END, 32'hFFFF_FFFF));
    send(make_cmd(FUNC_SET, 16'hFFFF, UNIT_HOUR, REQ_START, 32'd0));
    // Ten maximal hour loads push the count past the 31-bit ceiling.
    repeat (9) send(make_cmd(FUNC_ADD, 16'hFFFF, UNIT_HOUR, REQ_START, 32'd0));
    send(make_cmd(FUNC_SUB, 16'hFFFF, UNIT_NONE, REQ_START, 32'd0));
    send(make_cmd(FUNC_SUB, 16'hFFFF, UNIT_MIN, REQ_START, 32'd0));
    send(make_cmd(FUNC_ACTION, 16'd0, UNIT_SEC, REQ_START, 32'd0));
    send(make_cmd(FUNC_ACTION, 16'd0, UNIT_SEC, REQ_START, 32'd0));
    send(make_cmd(FUNC_TICK, 16'd0, UNIT_SEC, REQ_START, 32'd5));
    send(make_cmd(FUNC_TICK, 16'd0, UNIT_SEC, REQ_START, 32'hFFFF_FFFF));
    send(make_cmd(FUNC_TICK, 16'd0, UNIT_SEC, REQ_START, 32'd0));
    // Elapsed time exceeds the new amount, so the load clamps at zero.
    send(make_cmd(FUNC_SET_KEEP, 16'd1, UNIT_SEC, REQ_START, 32'd0));
    send(make_cmd(FUNC_TICK, 16'd0, UNIT_SEC, REQ_START, 32'd7));
    send(make_cmd(FUNC_ACTION, 16'd0, UNIT_SEC, REQ_PAUSE, 32'd0));
    send(make_cmd(FUNC_SET, 16'd2, UNIT_SEC, REQ_START, 32'd0));
    send(make_cmd(FUNC_SUB, 16'd5, UNIT_SEC, REQ_START, 32'd0));
    send(make_cmd(FUNC_TICK, 16'd0, UNIT_SEC, REQ_START, 32'd9));
    send(make_cmd(FUNC_ACTION, 16'd0, UNIT_SEC, REQ_STOP, 32'd0));
    send(make_cmd(FUNC_SET, 16'd9, UNIT_SEC, REQ_START, 32'd0));
    send(make_cmd(FUNC_TICK, 16'd0, UNIT_SEC, REQ_START, 32'd11));
    send(make_cmd(FUNC_RESET, 16'd0, UNIT_SEC, REQ_START, 32'd0));
    send(make_cmd(FUNC_ACTION, 16'd0, UNIT_SEC, REQ_END, 32'd0));
    clock_ms = 32'd11;

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: configure(16'd1, 5'h1F);
        1: configure(16'd1000, 5'h00);
        2: configure(16'hFFFF, 5'($urandom));
        3: configure(16'($urandom_range(2, 50)), 5'h1F);
        4: configure(16'($urandom_range(1, 65535)), 5'($urandom));
        default: begin
          src_idle_en = 1'b0;
          snk_idle_en = 1'b0;
          configure(16'd5, 5'h1F);
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_episode();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
